[rtl/core/tlsu_pkg.sv]
// ----------------------------------------------------------------------------
// tlsu_pkg: shared types and constants of the torus lattice update block
// Holds the field widths, the register and direction codes, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlsu_pkg;

  localparam int unsigned FracW  = 16;
  localparam int unsigned CountW = 13;
  localparam int unsigned CoordW = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [FracW-1:0] FracReset = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRelativeRate     = 3'd0,
    CfgVerticalEgress   = 3'd1,
    CfgVerticalIngress  = 3'd2,
    CfgHorizontalEgress = 3'd3,
    CfgHorizontalIngress = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DirUp    = 2'd0,
    DirRight = 2'd1,
    DirDown  = 2'd2,
    DirLeft  = 2'd3
  } dir_e;

  typedef enum logic {
    KindLoad  = 1'b0,
    KindEvent = 1'b1
  } kind_e;

  typedef struct packed {
    logic clear;   // write one zero entry of the clearing pass
    logic read;    // capture an item and read its site and neighbour
    logic commit;  // write back the site and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last entry
  } dp_status_t;

endpackage

[rtl/core/tlsu_ctrl.sv]
// ----------------------------------------------------------------------------
// tlsu_ctrl: sequencing of the torus lattice update block
// Runs the clearing pass after reset, then takes one item at a time and
// tracks the occupancy of the result register.
// ----------------------------------------------------------------------------
module tlsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tlsu_pkg::dp_status_t status_i,
  output tlsu_pkg::ctrl_cmd_t  cmd_o
);
  import tlsu_pkg::*;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StEval
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign commit      = (state_q == StEval) && (!out_valid_q || out_ready_i);

  assign cmd_o.clear  = (state_q == StClear);
  assign cmd_o.read   = in_valid_i && in_ready_o;
  assign cmd_o.commit = commit;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StClear: begin
        if (status_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = StEval;
        end
      end
      StEval: begin
        // The result waits here until the result register is free.
        if (commit) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/tlsu_datapath.sv]
// ----------------------------------------------------------------------------
// tlsu_datapath: site memory, registers and update logic
// Holds the torus site memory with two read ports and one write port, the
// active site count, the threshold registers and the result register.
// ----------------------------------------------------------------------------
module tlsu_datapath #(
  parameter int unsigned SIDE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tlsu_pkg::ctrl_cmd_t               cmd_i,
  output tlsu_pkg::dp_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic [tlsu_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tlsu_pkg::FracW-1:0]        cfg_data_i,
  input  logic                              kind_i,
  input  logic [tlsu_pkg::CoordW-1:0]       row_i,
  input  logic [tlsu_pkg::CoordW-1:0]       col_i,
  input  logic                              load_value_i,
  input  logic [tlsu_pkg::FracW-1:0]        choice_random_i,
  input  logic [tlsu_pkg::FracW-1:0]        trial_random_i,
  input  logic [1:0]                        neighbour_dir_i,
  output logic                              site_value_o,
  output logic                              flipped_o,
  output logic [tlsu_pkg::CountW-1:0]       active_count_o
);
  import tlsu_pkg::*;

  localparam int unsigned RW    = $clog2(SIDE);
  localparam int unsigned AW    = 2 * RW;
  localparam int unsigned Depth = 1 << AW;
  localparam logic [RW-1:0] LastIdx = RW'(SIDE - 1);

  // Threshold registers.
  logic [FracW-1:0] rel_rate_q, v_egress_q, v_ingress_q, h_egress_q, h_ingress_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_rate_q  <= FracReset;
      v_egress_q  <= FracReset;
      v_ingress_q <= FracReset;
      h_egress_q  <= FracReset;
      h_ingress_q <= FracReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRelativeRate:      rel_rate_q  <= cfg_data_i;
        CfgVerticalEgress:    v_egress_q  <= cfg_data_i;
        CfgVerticalIngress:   v_ingress_q <= cfg_data_i;
        CfgHorizontalEgress:  h_egress_q  <= cfg_data_i;
        CfgHorizontalIngress: h_ingress_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address generation for the incoming item.
  logic          in_range;
  logic [RW-1:0] r, c, nr, nc;
  logic [AW-1:0] site_addr, nb_addr;

  assign in_range  = (32'(row_i) < SIDE) && (32'(col_i) < SIDE);
  assign r         = RW'(row_i);
  assign c         = RW'(col_i);
  assign site_addr = {r, c};
  assign nb_addr   = {nr, nc};

  always_comb begin
    nr = r;
    nc = c;
    unique case (dir_e'(neighbour_dir_i))
      DirUp:    nr = (r == '0) ? LastIdx : r - RW'(1);
      DirRight: nc = (c == LastIdx) ? '0 : c + RW'(1);
      DirDown:  nr = (r == LastIdx) ? '0 : r + RW'(1);
      DirLeft:  nc = (c == '0) ? LastIdx : c - RW'(1);
      default:  nr = r;
    endcase
  end

  // Captured item.
  logic             kind_q, in_range_q, load_q;
  logic [AW-1:0]    addr_q;
  logic [FracW-1:0] choice_q, trial_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      kind_q     <= kind_i;
      in_range_q <= in_range;
      load_q     <= load_value_i;
      addr_q     <= site_addr;
      choice_q   <= choice_random_i;
      trial_q    <= trial_random_i;
    end
  end

  // Site memory with its clearing pass.
  logic          mem [Depth];
  logic          site_rd_q, nb_rd_q;
  logic [AW-1:0] clr_addr_q;
  logic          after_val, before_val;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;

  assign status_o.clear_last = (clr_addr_q == '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign mem_we    = cmd_i.clear || (cmd_i.commit && in_range_q);
  assign mem_waddr = cmd_i.clear ? clr_addr_q : addr_q;
  assign mem_wdata = cmd_i.clear ? 1'b0 : after_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      site_rd_q <= mem[site_addr];
      nb_rd_q   <= mem[nb_addr];
    end
  end

  // Update rule.
  logic flip_v;

  always_comb begin
    before_val = site_rd_q && in_range_q;
    flip_v     = site_rd_q ? (trial_q < v_egress_q) : (trial_q < v_ingress_q);
    if (!in_range_q) begin
      after_val = 1'b0;
    end else if (kind_e'(kind_q) == KindLoad) begin
      after_val = load_q;
    end else if (choice_q > rel_rate_q) begin
      after_val = site_rd_q ^ flip_v;
    end else if (nb_rd_q) begin
      after_val = (trial_q > h_egress_q);
    end else begin
      after_val = (trial_q <= h_ingress_q);
    end
  end

  // Active count and result register.
  logic [CountW-1:0] count_q, count_d;
  logic              site_q, flipped_q;

  always_comb begin
    count_d = count_q;
    if (after_val && !before_val) begin
      count_d = count_q + CountW'(1);
    end else if (!after_val && before_val) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      site_q    <= after_val;
      flipped_q <= after_val ^ before_val;
    end
  end

  assign site_value_o   = site_q;
  assign flipped_o      = flipped_q;
  assign active_count_o = count_q;

endmodule

[rtl/core/torus_lattice_stochastic_update.sv]
// An accepted item waits in StEval until the result register is free, then
// commits, and out_valid_o rises from its register. Items go one at a time:
// each is read from the site memory and written back before the next is
// taken; a new item is taken while a result waits. Reset: thresholds return to
// one half and the count to zero, then a clearing pass zeroes the site memory,
// one entry a cycle, with in_ready_o low; configuration is always taken.
// ----------------------------------------------------------------------------
// torus_lattice_stochastic_update: voter-style Monte Carlo update on a torus
// Loads single sites or applies one stochastic vertical or horizontal event
// to an addressed site, and reports its new value and the active count.
// ----------------------------------------------------------------------------
module torus_lattice_stochastic_update #(
  parameter int unsigned SIDE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tlsu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tlsu_pkg::FracW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [tlsu_pkg::CoordW-1:0]  row_i,
  input  logic [tlsu_pkg::CoordW-1:0]  col_i,
  input  logic                         load_value_i,
  input  logic [tlsu_pkg::FracW-1:0]   choice_random_i,
  input  logic [tlsu_pkg::FracW-1:0]   trial_random_i,
  input  logic [1:0]                   neighbour_dir_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         site_value_o,
  output logic                         flipped_o,
  output logic [tlsu_pkg::CountW-1:0]  active_count_o
);
  import tlsu_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tlsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tlsu_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .load_value_i    (load_value_i),
    .choice_random_i (choice_random_i),
    .trial_random_i  (trial_random_i),
    .neighbour_dir_i (neighbour_dir_i),
    .site_value_o    (site_value_o),
    .flipped_o       (flipped_o),
    .active_count_o  (active_count_o)
  );

endmodule

[sim/torus_lattice_stochastic_update_tb.sv]
// ----------------------------------------------------------------------------
// torus_lattice_stochastic_update_tb: self-checking bench for the torus update
// Loads sites and fires vertical and horizontal events at the block, first a
// directed set around the grid edges and the threshold boundaries, then random
// items clustered in small windows so that neighbors interact. A scoreboard
// keeps its own copy of the grid, the count and the thresholds.
// ----------------------------------------------------------------------------

localparam int unsigned LatticeSide = 64;
localparam int unsigned GridAW      = $clog2(LatticeSide * LatticeSide);

typedef struct packed {
  tlsu_pkg::kind_e                 kind;
  logic [tlsu_pkg::CoordW-1:0]     row;
  logic [tlsu_pkg::CoordW-1:0]     col;
  logic                            load_value;
  logic [tlsu_pkg::FracW-1:0]      choice_rnd;
  logic [tlsu_pkg::FracW-1:0]      trial_rnd;
  tlsu_pkg::dir_e                  dir;
} lattice_item_t;

typedef struct packed {
  logic                            site_value;
  logic                            flipped;
  logic [tlsu_pkg::CountW-1:0]     active_count;
} site_update_t;

class lattice_scoreboard;
  bit                          grid [LatticeSide*LatticeSide];
  int unsigned                 active_sites;
  logic [tlsu_pkg::FracW-1:0]  rate_thr;
  logic [tlsu_pkg::FracW-1:0]  v_egress;
  logic [tlsu_pkg::FracW-1:0]  v_ingress;
  logic [tlsu_pkg::FracW-1:0]  h_egress;
  logic [tlsu_pkg::FracW-1:0]  h_ingress;
  site_update_t                updates_due [$];
  int unsigned                 failures;

  function new();
    foreach (grid[i]) grid[i] = 1'b0;
    active_sites = 0;
    rate_thr  = tlsu_pkg::FracReset;
    v_egress  = tlsu_pkg::FracReset;
    v_ingress = tlsu_pkg::FracReset;
    h_egress  = tlsu_pkg::FracReset;
    h_ingress = tlsu_pkg::FracReset;
    failures  = 0;
  endfunction

  function void write_reg(logic [tlsu_pkg::CfgIdxW-1:0] idx, logic [tlsu_pkg::FracW-1:0] data);
    case (idx)
      tlsu_pkg::CfgRelativeRate:      rate_thr  = data;
      tlsu_pkg::CfgVerticalEgress:    v_egress  = data;
      tlsu_pkg::CfgVerticalIngress:   v_ingress = data;
      tlsu_pkg::CfgHorizontalEgress:  h_egress  = data;
      tlsu_pkg::CfgHorizontalIngress: h_ingress = data;
      default: ;
    endcase
  endfunction

  function void note_input(lattice_item_t it);
    int unsigned  here;
    int unsigned  nb_row;
    int unsigned  nb_col;
    logic         old_bit;
    logic         new_bit;
    site_update_t want;
    old_bit = 1'b0;
    new_bit = 1'b0;
    if (it.row < LatticeSide && it.col < LatticeSide) begin
      here    = it.row * LatticeSide + it.col;
      old_bit = grid[GridAW'(here)];
      nb_row  = 32'(it.row);
      nb_col  = 32'(it.col);
      if (it.kind == tlsu_pkg::KindLoad) begin
        new_bit = it.load_value;
      end else if (it.choice_rnd > rate_thr) begin
        // Vertical event: an active site survives unless the trial is below egress.
        new_bit = old_bit ? (it.trial_rnd >= v_egress) : (it.trial_rnd < v_ingress);
      end else begin
        case (it.dir)
          tlsu_pkg::DirUp:    nb_row = (it.row + LatticeSide - 1) % LatticeSide;
          tlsu_pkg::DirRight: nb_col = (it.col + 1) % LatticeSide;
          tlsu_pkg::DirDown:  nb_row = (it.row + 1) % LatticeSide;
          default:            nb_col = (it.col + LatticeSide - 1) % LatticeSide;
        endcase
        if (grid[GridAW'(nb_row * LatticeSide + nb_col)]) new_bit = (it.trial_rnd > h_egress);
        else new_bit = (it.trial_rnd <= h_ingress);
      end
      if (new_bit != old_bit) begin
        grid[GridAW'(here)] = new_bit;
        if (new_bit) active_sites++;
        else active_sites--;
      end
    end
    want.site_value   = new_bit;
    want.flipped      = old_bit ^ new_bit;
    want.active_count = active_sites[tlsu_pkg::CountW-1:0];
    updates_due = {updates_due, want};
  endfunction

  function void flag(string what, int unsigned exp_val, int unsigned act_val);
    failures++;
    if (failures <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
  endfunction

  function void check_result(site_update_t got);
    site_update_t want;
    if (updates_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: result with nothing pending (site %0d flipped %0d count %0d)",
                 $time, got.site_value, got.flipped, got.active_count);
      return;
    end
    want = updates_due.pop_front();
    if (got.site_value !== want.site_value)
      flag("site_value", 32'(want.site_value), 32'(got.site_value));
    if (got.flipped !== want.flipped) flag("flipped", 32'(want.flipped), 32'(got.flipped));
    if (got.active_count !== want.active_count)
      flag("active_count", 32'(want.active_count), 32'(got.active_count));
  endfunction

  function int unsigned pending();
    return updates_due.size();
  endfunction
endclass

module torus_lattice_stochastic_update_tb;
  import tlsu_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgFirstUnused = 3'd5;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 330;
  localparam int unsigned HoldCycles  = 64;
  localparam logic [FracW-1:0] FracMax = 16'hFFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [FracW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [CoordW-1:0]  row_i;
  logic [CoordW-1:0]  col_i;
  logic               load_value_i;
  logic [FracW-1:0]   choice_random_i;
  logic [FracW-1:0]   trial_random_i;
  logic [1:0]         neighbour_dir_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               site_value_o;
  logic               flipped_o;
  logic [CountW-1:0]  active_count_o;

  lattice_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  torus_lattice_stochastic_update #(.SIDE(LatticeSide)) DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #600000;
    $display("[torus_lattice_stochastic_update] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{site_value_o, flipped_o, active_count_o});
  end

  // Result side: short random stalls, and one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic lattice_item_t make_load(int unsigned r, int unsigned c, bit v);
    lattice_item_t it;
    it = '0;
    it.kind       = KindLoad;
    it.row        = CoordW'(r);
    it.col        = CoordW'(c);
    it.load_value = v;
    it.choice_rnd = FracW'($urandom_range(0, 65535));
    it.trial_rnd  = FracW'($urandom_range(0, 65535));
    it.dir        = dir_e'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic lattice_item_t make_event(int unsigned r, int unsigned c,
                                               logic [FracW-1:0] ch, logic [FracW-1:0] tr,
                                               dir_e d);
    lattice_item_t it;
    it.kind       = KindEvent;
    it.row        = CoordW'(r);
    it.col        = CoordW'(c);
    it.load_value = 1'($urandom_range(0, 1));
    it.choice_rnd = ch;
    it.trial_rnd  = tr;
    it.dir        = d;
    return it;
  endfunction

  // Most items land in a 4 by 4 window so that sites see active neighbors.
  function automatic lattice_item_t pick_lattice_item(int unsigned base_row,
                                                      int unsigned base_col);
    lattice_item_t it;
    int unsigned   r;
    int unsigned   c;
    logic [FracW-1:0] ch;
    logic [FracW-1:0] tr;
    if ($urandom_range(0, 3) != 0) begin
      r = (base_row + $urandom_range(0, 3)) % LatticeSide;
      c = (base_col + $urandom_range(0, 3)) % LatticeSide;
    end else begin
      r = $urandom_range(0, LatticeSide - 1);
      c = $urandom_range(0, LatticeSide - 1);
    end
    if ($urandom_range(0, 9) < 3) return make_load(r, c, 1'($urandom_range(0, 1)));
    ch = ($urandom_range(0, 7) == 0) ? sb.rate_thr : FracW'($urandom_range(0, 65535));
    case ($urandom_range(0, 11))
      0: tr = sb.v_egress;
      1: tr = sb.v_ingress;
      2: tr = sb.h_egress;
      3: tr = sb.h_ingress;
      default: tr = FracW'($urandom_range(0, 65535));
    endcase
    it = make_event(r, c, ch, tr, dir_e'($urandom_range(0, 3)));
    return it;
  endfunction

  task automatic send_item(input lattice_item_t it);
    in_valid_i      <= 1'b1;
    kind_i          <= it.kind;
    row_i           <= it.row;
    col_i           <= it.col;
    load_value_i    <= it.load_value;
    choice_random_i <= it.choice_rnd;
    trial_random_i  <= it.trial_rnd;
    neighbour_dir_i <= it.dir;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_input(it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [FracW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Writes all five thresholds, then a register index that does not exist.
  task automatic program_thresholds(input logic [FracW-1:0] rate, input logic [FracW-1:0] ve,
                                    input logic [FracW-1:0] vi, input logic [FracW-1:0] he,
                                    input logic [FracW-1:0] hi);
    write_reg(CfgRelativeRate, rate);
    write_reg(CfgVerticalEgress, ve);
    write_reg(CfgVerticalIngress, vi);
    write_reg(CfgHorizontalEgress, he);
    write_reg(CfgHorizontalIngress, hi);
    write_reg(CfgFirstUnused + CfgIdxW'($urandom_range(0, 2)),
              FracW'($urandom_range(0, 65535)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned base_row;
    int unsigned base_col;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = 1'b0;
    row_i           = '0;
    col_i           = '0;
    load_value_i    = 1'b0;
    choice_random_i = '0;
    trial_random_i  = '0;
    neighbour_dir_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers are taken during the clearing pass; items wait for it to finish.
    program_thresholds(FracReset, FracReset, FracReset, FracReset, FracReset);

    // Corner sites and their wrapped neighbors, then the threshold boundaries.
    send_item(make_load(0, 0, 1'b1));
    send_item(make_load(0, 0, 1'b1));
    send_item(make_load(63, 0, 1'b1));
    send_item(make_load(0, 63, 1'b1));
    send_item(make_load(63, 63, 1'b0));
    send_item(make_event(0, 0, 16'd0, 16'd0, DirUp));
    send_item(make_event(0, 0, FracReset, FracMax, DirLeft));
    send_item(make_event(0, 0, 16'd0, FracReset, DirLeft));
    send_item(make_event(0, 0, 16'd0, FracReset, DirRight));
    send_item(make_event(0, 0, 16'd0, FracMax, DirDown));
    send_item(make_event(63, 63, 16'd0, 16'd0, DirDown));
    send_item(make_event(63, 63, 16'd0, 16'd0, DirRight));
    send_item(make_event(63, 63, FracMax, FracReset - 16'd1, DirUp));
    send_item(make_event(63, 63, FracMax, FracReset, DirUp));
    send_item(make_event(63, 63, FracReset + 16'd1, 16'd0, DirLeft));
    send_item(make_event(63, 63, FracMax, FracMax, DirLeft));
    send_item(make_load(42, 21, 1'b1));
    send_item(make_load(21, 42, 1'b1));
    send_item(make_event(42, 21, FracMax, 16'd0, DirUp));
    send_item(make_event(21, 42, 16'd0, FracMax, DirRight));
    drain();

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: program_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: program_thresholds(FracMax, FracMax, FracMax, FracMax, FracMax);
        default: program_thresholds(FracW'($urandom_range(0, 65535)),
                                    FracW'($urandom_range(0, 65535)),
                                    FracW'($urandom_range(0, 65535)),
                                    FracW'($urandom_range(0, 65535)),
                                    FracW'($urandom_range(0, 65535)));
      endcase
      quiet = (phase == NumPhases - 1);
      // The first window straddles the wrap corner.
      base_row = (phase == 0) ? LatticeSide - 2 : $urandom_range(0, LatticeSide - 1);
      base_col = (phase == 0) ? LatticeSide - 2 : $urandom_range(0, LatticeSide - 1);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == PhaseItems / 3) hold_req = 1'b1;
        send_item(pick_lattice_item(base_row, base_col));
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("[torus_lattice_stochastic_update] OK");
    end else begin
      $display("[torus_lattice_stochastic_update] ERROR");
    end
    $finish;
  end

endmodule
